// ===== hw/rtl/rmst_pkg.sv =====
// Shared types and constants for the range-maximum segment tree.
// Holds the request and response payloads, operation codes and the
// control and status groups between the top level and the core.
package rmst_pkg;

   localparam int OP_W    = 3;
   localparam int IDX_W   = 10;
   localparam int END_W   = 11;
   localparam int DATA_W  = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR = 3'd0,
      OP_SET   = 3'd1,
      OP_GET   = 3'd2,
      OP_RANGE = 3'd3,
      OP_STEP  = 3'd4
   } rmst_op_type;

   typedef struct packed {
      logic [OP_W-1:0]   operation;
      logic [IDX_W-1:0]  leaf_index;
      logic [END_W-1:0]  range_end;
      logic [DATA_W-1:0] new_value;
   } rmst_req_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              leaf_updated;
      logic [DATA_W-1:0] best_length;
   } rmst_rsp_type;

   typedef struct packed {
      logic start;
      logic out_free;
   } rmst_ctrl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } rmst_stat_type;

endpackage

// ===== hw/rtl/rmst_core.sv =====
// Sequencer and node memory of the range-maximum segment tree.
// Depends on rmst_pkg for the payload, operation, control and status types.
module rmst_core #(
   parameter int LEAVES     = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rmst_pkg::rmst_ctrl_type ctrl,
   input  rmst_pkg::rmst_req_type  req_data,
   output rmst_pkg::rmst_stat_type stat,
   output rmst_pkg::rmst_rsp_type  rsp_data
);
   import rmst_pkg::*;

   localparam int NODES = 2 * LEAVES;
   localparam int AW    = $clog2(NODES);
   localparam int CNT_W = $clog2(NODES + 1);
   localparam int CMP_W = (CNT_W > END_W) ? CNT_W : END_W;
   localparam int EXT_W = (VALUE_BITS > DATA_W) ? VALUE_BITS : DATA_W;
   localparam logic [CMP_W-1:0] LEAVES_C = CMP_W'(LEAVES);
   localparam logic [AW-1:0]    ROOT     = AW'(1);
   localparam logic [AW-1:0]    LAST     = AW'(NODES - 1);

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_START    = 9'b000000100,
      ST_SET_LEAF = 9'b000001000,
      ST_WALK     = 9'b000010000,
      ST_QUERY    = 9'b000100000,
      ST_LEAF_RD  = 9'b001000000,
      ST_LEAF_CHK = 9'b010000000,
      ST_DONE     = 9'b100000000
   } state_type;

   logic [VALUE_BITS-1:0] tree_ff [NODES];
   logic [VALUE_BITS-1:0] rdata_ff;

   state_type             state_ff, state_in;
   rmst_req_type          req_ff, req_in;
   logic [CNT_W-1:0]      l_ff, l_in, r_ff, r_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  rpend_ff, rpend_in;
   logic [AW-1:0]         path_ff, path_in;
   logic [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [VALUE_BITS-1:0] best_ff, best_in;
   logic [VALUE_BITS-1:0] res_ff, res_in;
   logic                  upd_ff, upd_in;
   logic [AW-1:0]         clr_addr_ff, clr_addr_in;
   logic                  clr_reply_ff, clr_reply_in;

   logic                  wr_en, rd_en, done;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [VALUE_BITS-1:0] wr_data;

   logic [CMP_W-1:0]      idx_ext, end_ext, end_clamp, pre_clamp;
   logic [CMP_W-1:0]      leaf_sum, rng_hi, pre_hi;
   logic                  in_range;
   logic [AW-1:0]         leaf_addr, parent;
   logic [EXT_W-1:0]      nv_ext, res_ext, best_ext;
   logic [VALUE_BITS-1:0] nv_val, acc_sat, walk_max;
   logic [CNT_W-1:0]      l_inc, r_dec;

   assign idx_ext   = CMP_W'(req_ff.leaf_index);
   assign end_ext   = CMP_W'(req_ff.range_end);
   assign in_range  = idx_ext < LEAVES_C;
   assign end_clamp = (end_ext > LEAVES_C) ? LEAVES_C : end_ext;
   assign pre_clamp = in_range ? idx_ext : LEAVES_C;
   assign leaf_sum  = idx_ext + LEAVES_C;
   assign rng_hi    = end_clamp + LEAVES_C;
   assign pre_hi    = pre_clamp + LEAVES_C;
   assign leaf_addr = leaf_sum[AW-1:0];
   assign parent    = path_ff >> 1;
   assign nv_ext    = EXT_W'(req_ff.new_value);
   assign nv_val    = nv_ext[VALUE_BITS-1:0];
   assign acc_sat   = (&acc_ff) ? acc_ff : acc_ff + VALUE_BITS'(1);
   assign walk_max  = (rdata_ff > cur_ff) ? rdata_ff : cur_ff;
   assign l_inc     = l_ff + CNT_W'(1);
   assign r_dec     = r_ff - CNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      rpend_in     = 1'b0;
      path_in      = path_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      res_in       = res_ff;
      upd_in       = upd_ff;
      clr_addr_in  = clr_addr_ff;
      clr_reply_in = clr_reply_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = leaf_addr;
      done         = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST) begin
               res_in   = '0;
               upd_in   = 1'b0;
               state_in = clr_reply_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (ctrl.start) begin
               req_in   = req_data;
               state_in = ST_START;
            end
         end
         ST_START: begin
            upd_in = 1'b0;
            res_in = '0;
            acc_in = '0;
            case (req_ff.operation)
               OP_CLEAR: begin
                  best_in      = '0;
                  clr_addr_in  = '0;
                  clr_reply_in = 1'b1;
                  state_in     = ST_CLEAR;
               end
               OP_SET: begin
                  cur_in   = nv_val;
                  res_in   = nv_val;
                  state_in = in_range ? ST_SET_LEAF : ST_DONE;
               end
               OP_GET: begin
                  state_in = in_range ? ST_LEAF_RD : ST_DONE;
               end
               OP_RANGE: begin
                  if (idx_ext < end_clamp) begin
                     l_in = CNT_W'(leaf_sum);
                     r_in = CNT_W'(rng_hi);
                  end else begin
                     l_in = '0;
                     r_in = '0;
                  end
                  state_in = ST_QUERY;
               end
               OP_STEP: begin
                  l_in     = CNT_W'(LEAVES_C);
                  r_in     = CNT_W'(pre_hi);
                  state_in = ST_QUERY;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_QUERY: begin
            if (rpend_ff) begin
               acc_in = (rdata_ff > acc_ff) ? rdata_ff : acc_ff;
            end
            if (l_ff < r_ff) begin
               if (l_ff[0]) begin
                  rd_en    = 1'b1;
                  rd_addr  = l_ff[AW-1:0];
                  rpend_in = 1'b1;
                  if (r_ff[0]) begin
                     l_in = l_inc;
                  end else begin
                     l_in = l_inc >> 1;
                     r_in = r_ff >> 1;
                  end
               end else if (r_ff[0]) begin
                  rd_en    = 1'b1;
                  rd_addr  = r_dec[AW-1:0];
                  rpend_in = 1'b1;
                  l_in     = l_ff >> 1;
                  r_in     = r_dec >> 1;
               end else begin
                  l_in = l_ff >> 1;
                  r_in = r_ff >> 1;
               end
            end else if (!rpend_ff) begin
               if (req_ff.operation == OP_STEP) begin
                  res_in   = acc_sat;
                  state_in = in_range ? ST_LEAF_RD : ST_DONE;
               end else begin
                  res_in   = acc_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_LEAF_RD: begin
            rd_en    = 1'b1;
            rd_addr  = leaf_addr;
            state_in = ST_LEAF_CHK;
         end
         ST_LEAF_CHK: begin
            if (req_ff.operation == OP_STEP) begin
               if (rdata_ff < res_ff) begin
                  upd_in   = 1'b1;
                  best_in  = (res_ff > best_ff) ? res_ff : best_ff;
                  cur_in   = res_ff;
                  state_in = ST_SET_LEAF;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               res_in   = rdata_ff;
               state_in = ST_DONE;
            end
         end
         ST_SET_LEAF: begin
            wr_en    = 1'b1;
            wr_addr  = leaf_addr;
            wr_data  = cur_ff;
            rd_en    = 1'b1;
            rd_addr  = leaf_addr ^ ROOT;
            path_in  = leaf_addr;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (path_ff == ROOT) begin
               state_in = ST_DONE;
            end else begin
               wr_en   = 1'b1;
               wr_addr = parent;
               wr_data = walk_max;
               cur_in  = walk_max;
               path_in = parent;
               rd_en   = 1'b1;
               rd_addr = parent ^ ROOT;
            end
         end
         ST_DONE: begin
            if (ctrl.out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= tree_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         rpend_ff     <= 1'b0;
         best_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         rpend_ff     <= rpend_in;
         best_ff      <= best_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      acc_ff  <= acc_in;
      path_ff <= path_in;
      cur_ff  <= cur_in;
      res_ff  <= res_in;
      upd_ff  <= upd_in;
   end

   assign res_ext  = EXT_W'(res_ff);
   assign best_ext = EXT_W'(best_ff);

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = done;

   assign rsp_data.result_value = res_ext[DATA_W-1:0];
   assign rsp_data.leaf_updated = upd_ff;
   assign rsp_data.best_length  = best_ext[DATA_W-1:0];

endmodule

// ===== hw/rtl/range_max_segment_tree.sv =====
// Top level of the range-maximum segment tree: request acceptance and the
// response register. Depends on rmst_pkg and instantiates rmst_core.
//
// The block handles one request at a time; every request gives exactly one
// response. All tree nodes live in a memory of 2*LEAVES words with one
// write and one read port. Get leaf reads the leaf word; set leaf makes one
// memory write per level, the sibling read overlapping the parent write;
// range max reads at most one node per cycle and two per level at worst;
// and a subsequence step runs the prefix query, then a leaf read and, when
// the leaf rises, the set walk. Clear writes every node once.
// After reset the same clearing pass runs before req_ready first rises.
// A new request can be accepted while the previous response still waits in
// the output register.
module range_max_segment_tree #(
   parameter int LEAVES     = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rmst_pkg::rmst_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rmst_pkg::rmst_rsp_type rsp_data
);
   import rmst_pkg::*;

   rmst_ctrl_type ctrl;
   rmst_stat_type stat;
   rmst_rsp_type  core_rsp;
   rmst_rsp_type  rsp_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_ready     = stat.idle;
   assign ctrl.start    = req_valid && stat.idle;
   assign ctrl.out_free = !rsp_valid_ff || rsp_ready;

   rmst_core #(
      .LEAVES     (LEAVES),
      .VALUE_BITS (VALUE_BITS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (core_rsp)
   );

   always_comb begin
      if (stat.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stat.done) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for range_max_segment_tree: a queue-fed driver,
// a response monitor and a predictor of the tree of maximums and best length.
// Depends on rmst_pkg and the range_max_segment_tree top level.
module tb;
   import rmst_pkg::*;

   localparam int LEAVES       = 1024;
   localparam int NODE_COUNT   = 2 * LEAVES;
   localparam int IDLE_PERCENT = 24;
   localparam int RANDOM_ITEMS = 700;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int TAIL_CYCLES  = 64;
   localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;
   localparam logic [DATA_W-1:0] VALUE_TOP = '1;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   rmst_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rmst_rsp_type rsp_data;

   rmst_req_type queued_requests[$];
   rmst_rsp_type pending_answers[$];
   logic [DATA_W-1:0] tree_max [0:NODE_COUNT-1];
   logic [DATA_W-1:0] longest_run;

   int  cycle_count = 0;
   int  issued_count = 0;
   int  accepted_count = 0;
   int  checked_count = 0;
   int  error_count = 0;
   int  raised_count = 0;
   int  op_seen [0:7];
   logic quiet;

   assign quiet = ((cycle_count / 4096) % 4) == 1;

   range_max_segment_tree #(
      .LEAVES     (LEAVES),
      .VALUE_BITS (DATA_W)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void raise_leaf(int unsigned leaf, logic [DATA_W-1:0] value);
      int unsigned k;
      k = leaf + LEAVES;
      tree_max[k] = value;
      k = k >> 1;
      while (k > 0) begin
         tree_max[k] = (tree_max[2*k] > tree_max[2*k+1]) ? tree_max[2*k] : tree_max[2*k+1];
         k = k >> 1;
      end
   endfunction

   function automatic logic [DATA_W-1:0] max_over(int unsigned lo, int unsigned hi);
      int unsigned l;
      int unsigned r;
      logic [DATA_W-1:0] acc;
      acc = '0;
      if (hi > LEAVES) begin
         hi = LEAVES;
      end
      if (lo >= hi) begin
         return '0;
      end
      l = lo + LEAVES;
      r = hi + LEAVES;
      while (l < r) begin
         if (l[0]) begin
            if (tree_max[l] > acc) acc = tree_max[l];
            l++;
         end
         if (r[0]) begin
            r--;
            if (tree_max[r] > acc) acc = tree_max[r];
         end
         l = l >> 1;
         r = r >> 1;
      end
      return acc;
   endfunction

   function automatic rmst_rsp_type compute_answer(rmst_req_type req);
      rmst_rsp_type ans;
      logic [DATA_W-1:0] prefix;
      ans = '0;
      case (req.operation)
         OP_CLEAR: begin
            for (int n = 0; n < NODE_COUNT; n++) tree_max[n] = '0;
            longest_run = '0;
         end
         OP_SET: begin
            raise_leaf(req.leaf_index, req.new_value);
            ans.result_value = req.new_value;
         end
         OP_GET: begin
            ans.result_value = tree_max[req.leaf_index + LEAVES];
         end
         OP_RANGE: begin
            ans.result_value = max_over(req.leaf_index, req.range_end);
         end
         OP_STEP: begin
            prefix = max_over(0, req.leaf_index);
            ans.result_value = (prefix == VALUE_TOP) ? VALUE_TOP : prefix + 1'b1;
            if (tree_max[req.leaf_index + LEAVES] < ans.result_value) begin
               raise_leaf(req.leaf_index, ans.result_value);
               ans.leaf_updated = 1'b1;
               if (ans.result_value > longest_run) longest_run = ans.result_value;
            end
         end
         default: begin
         end
      endcase
      ans.best_length = longest_run;
      return ans;
   endfunction

   task automatic add_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                           logic [END_W-1:0] stop, logic [DATA_W-1:0] value);
      rmst_req_type req;
      req.operation  = op;
      req.leaf_index = idx;
      req.range_end  = stop;
      req.new_value  = value;
      queued_requests.insert(queued_requests.size(), req);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || accepted_count == issued_count) begin
         if (queued_requests.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_data <= queued_requests.pop_front();
            issued_count <= issued_count + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      rmst_rsp_type want;
      rmst_rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = rsp_data;
         checked_count++;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response, got %h", $time, got);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (got.result_value !== want.result_value) begin
               $display("%0t: result_value expected %h, got %h",
                        $time, want.result_value, got.result_value);
               error_count++;
            end
            if (got.leaf_updated !== want.leaf_updated) begin
               $display("%0t: leaf_updated expected %b, got %b",
                        $time, want.leaf_updated, got.leaf_updated);
               error_count++;
            end
            if (got.best_length !== want.best_length) begin
               $display("%0t: best_length expected %h, got %h",
                        $time, want.best_length, got.best_length);
               error_count++;
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         want = compute_answer(req_data);
         pending_answers.insert(pending_answers.size(), want);
         op_seen[req_data.operation]++;
         if (want.leaf_updated) raised_count++;
         accepted_count <= accepted_count + 1;
      end
   end

   initial begin
      int made;
      int pick;
      logic [63:0] raw;
      rmst_req_type req;
      for (int n = 0; n < NODE_COUNT; n++) tree_max[n] = '0;
      for (int n = 0; n < 8; n++) op_seen[n] = 0;
      longest_run = '0;

      // Directed part: field extremes, clamping, empty ranges and saturation.
      add_item(OP_GET,   10'd0,    11'd0,    32'd0);
      add_item(OP_SET,   10'd0,    11'd0,    32'hFFFF_FFFF);
      add_item(OP_SET,   10'd1023, 11'd2047, 32'd1);
      add_item(OP_GET,   10'd1023, 11'd0,    32'hFFFF_FFFF);
      add_item(OP_RANGE, 10'd0,    11'd1024, 32'd0);
      add_item(OP_RANGE, 10'd1,    11'd2047, 32'd0);
      add_item(OP_RANGE, 10'd5,    11'd5,    32'd0);
      add_item(OP_RANGE, 10'd1023, 11'd1000, 32'd0);
      add_item(OP_RANGE, 10'd1023, 11'd1024, 32'd0);
      add_item(OP_STEP,  10'd5,    11'd0,    32'd0);
      add_item(OP_STEP,  10'd5,    11'd2047, 32'hFFFF_FFFF);
      add_item(OP_CLEAR, 10'd1023, 11'd2047, 32'hFFFF_FFFF);
      add_item(OP_STEP,  10'd0,    11'd0,    32'd0);
      add_item(OP_STEP,  10'd3,    11'd0,    32'd0);
      add_item(OP_STEP,  10'd1023, 11'd0,    32'd0);
      add_item(OP_SET,   10'd2,    11'd0,    32'hFFFF_FFFE);
      add_item(OP_STEP,  10'd7,    11'd0,    32'd0);
      add_item(OP_GET,   10'd7,    11'd0,    32'd0);
      add_item(OP_SET,   10'd2,    11'd0,    32'd0);
      add_item(OP_RANGE, 10'd0,    11'd0,    32'd0);
      add_item(OP_RANGE, 10'd0,    11'd2047, 32'd0);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         add_item(OP_W'(op), 10'd1023, 11'd2047, 32'hFFFF_FFFF);
      end
      add_item(OP_CLEAR, 10'd0, 11'd0, 32'd0);

      // Random part: episodes of mixed traffic, mostly subsequence steps and
      // queries, with the occasional clear so that fresh chains are built.
      made = 0;
      while (made < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            add_item(OP_CLEAR, IDX_W'($urandom()), END_W'($urandom()), $urandom());
            made++;
         end
         for (int k = 0; k < 40; k++) begin
            raw = {$urandom(), $urandom()};
            req = raw[$bits(rmst_req_type)-1:0];
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               req.operation = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            end else if (pick < 20) begin
               req.operation = OP_SET;
               case ($urandom_range(0, 3))
                  0: req.new_value = $urandom_range(0, 15);
                  1: req.new_value = $urandom();
                  2: req.new_value = VALUE_TOP - $urandom_range(0, 2);
                  default: req.new_value = $urandom_range(0, 1000);
               endcase
               if ($urandom_range(0, 1)) req.leaf_index = IDX_W'($urandom_range(0, 63));
            end else if (pick < 32) begin
               req.operation = OP_GET;
               if ($urandom_range(0, 1)) req.leaf_index = IDX_W'($urandom_range(0, 63));
            end else if (pick < 52) begin
               req.operation = OP_RANGE;
               if ($urandom_range(0, 1)) begin
                  req.range_end = END_W'(req.leaf_index + $urandom_range(0, 80));
               end
            end else begin
               req.operation = OP_STEP;
               if ($urandom_range(0, 1)) req.leaf_index = IDX_W'($urandom_range(0, 63));
            end
            queued_requests.insert(queued_requests.size(), req);
            made++;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (queued_requests.size() != 0 || accepted_count != issued_count || req_valid) begin
         @(negedge clock);
      end
      while (pending_answers.size() != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Covered %0d requests: %0d clear, %0d set, %0d get, %0d range, %0d step",
               accepted_count, op_seen[OP_CLEAR], op_seen[OP_SET], op_seen[OP_GET],
               op_seen[OP_RANGE], op_seen[OP_STEP]);
      $display("Steps that raised a leaf: %0d; responses checked: %0d; mismatches: %0d",
               raised_count, checked_count, error_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/rmst_pkg.sv
hw/rtl/rmst_core.sv
hw/rtl/range_max_segment_tree.sv
tb/sv/tb.sv
